// File: sv/multiplexed_digit_fade_driver_defines.svh
`ifndef MULTIPLEXED_DIGIT_FADE_DRIVER_DEFINES_SVH
`define MULTIPLEXED_DIGIT_FADE_DRIVER_DEFINES_SVH

// Same-cycle check, switched off while in reset
`define MDFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check, switched off while in reset
`define MDFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mdfd_pkg.sv
package mdfd_pkg;

    // Default scan length
    localparam int NUM_DIGITS_DEFAULT = 6;

    // Fade animation
    localparam logic [7:0] FADE_DIVIDE = 8'd4;
    localparam logic [4:0] FADE_LAST   = 5'd24;   // 25 levels, 0..24
    localparam logic [4:0] FADE_SWAP   = 5'd12;   // new digit shown above this level

    // Digit codes
    localparam logic [7:0] OFF_CODE       = 8'd10;
    localparam logic [3:0] BLANK_INDEX    = 4'd10;
    localparam logic [7:0] PAIR_BLANK_MIN = 8'd100;

    // Request kinds (input tuser)
    localparam logic [2:0] REQ_SLOT    = 3'd0;
    localparam logic [2:0] REQ_COMPARE = 3'd1;
    localparam logic [2:0] REQ_DIGIT   = 3'd2;
    localparam logic [2:0] REQ_PAIR    = 3'd3;
    localparam logic [2:0] REQ_BLINK   = 3'd4;
    localparam logic [2:0] REQ_BRIGHT  = 3'd5;

    // Drive kinds (output tuser)
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BLANK = 2'd1;
    localparam logic [1:0] KIND_DRIVE = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Configuration register indexes (paddr bit 2)
    localparam logic CFG_FADE_MODE  = 1'b0;
    localparam logic CFG_MIN_BRIGHT = 1'b1;

    localparam logic [7:0] MIN_BRIGHT_RESET = 8'd10;

    // One digit position's state, held in the record memories
    typedef struct packed {
        logic [3:0] pending;
        logic [3:0] shown;
        logic [4:0] level;
        logic [7:0] divider;
        logic [7:0] compare;
        logic [7:0] bright;
        logic       blink;
    } digit_rec_t;

    localparam digit_rec_t REC_RESET = '{
        pending: 4'd0,
        shown:   4'd0,
        level:   5'd0,
        divider: 8'd0,
        compare: 8'd2,
        bright:  8'd253,
        blink:   1'b0
    };

    // Decoder port pattern, entry 10 is the off pattern
    function automatic logic [7:0] code_pattern(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h00;
            4'd1:    c = 8'h04;
            4'd2:    c = 8'h08;
            4'd3:    c = 8'h0C;
            4'd4:    c = 8'h10;
            4'd5:    c = 8'h14;
            4'd6:    c = 8'h18;
            4'd7:    c = 8'h1C;
            4'd8:    c = 8'h20;
            4'd9:    c = 8'h24;
            default: c = 8'h7C;
        endcase
        return c;
    endfunction

    // Fade envelope, rises to full and falls back
    function automatic logic [7:0] level_value(input logic [4:0] l);
        logic [7:0] v;
        case (l)
            5'd0:    v = 8'd1;
            5'd1:    v = 8'd40;
            5'd2:    v = 8'd70;
            5'd3:    v = 8'd90;
            5'd4:    v = 8'd120;
            5'd5:    v = 8'd150;
            5'd6:    v = 8'd170;
            5'd7:    v = 8'd190;
            5'd8:    v = 8'd210;
            5'd9:    v = 8'd230;
            5'd10:   v = 8'd240;
            5'd11:   v = 8'd250;
            5'd12:   v = 8'd250;
            5'd13:   v = 8'd250;
            5'd14:   v = 8'd240;
            5'd15:   v = 8'd230;
            5'd16:   v = 8'd210;
            5'd17:   v = 8'd190;
            5'd18:   v = 8'd170;
            5'd19:   v = 8'd150;
            5'd20:   v = 8'd120;
            5'd21:   v = 8'd90;
            5'd22:   v = 8'd70;
            5'd23:   v = 8'd40;
            5'd24:   v = 8'd1;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

endpackage

// File: sv/mdfd_ram.sv
module mdfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port (read returns old data on a clash)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/multiplexed_digit_fade_driver.sv
// Multiplexed display scanner with per-digit fade. Each input transaction is a
// slot tick, a compare tick or a register write, and gives exactly one output
// transaction. The block accepts one transaction per clock while the output is not stalled.
// The record read is issued on the accepting edge, and the result is loaded into the output
// register when the transaction moves on, together with the modify and write back. It then
// waits there for m_axis_tready while the next transaction is already read. Digit state lives in
// two record memories (even and odd positions) so that a pair write updates both digits at
// once; a bypass register covers a read of the entry written in the same cycle, and entries
// not yet written read as their reset state, so no clearing pass is needed. The user must write
// configuration over the APB port only while the stream is idle; the block does not enforce it.
module multiplexed_digit_fade_driver #(
    parameter int NUM_DIGITS = mdfd_pkg::NUM_DIGITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] digit_index, [10:3] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type

    // Drive results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] digit_select, [13:6] decoder_code,
                                        // [21:14] pwm_compare
    output logic [1:0]  m_axis_tuser    // [1:0] drive_kind
);

    localparam int BANK_DEPTH = (NUM_DIGITS + 1) / 2;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int REC_W      = $bits(mdfd_pkg::digit_rec_t);
    localparam logic [3:0] NUM_DIGITS_L = 4'(NUM_DIGITS);
    localparam logic [3:0] NUM_PAIRS_L  = 4'(NUM_DIGITS / 2);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    logic       fade_mode_reg,  fade_mode_next;
    logic [7:0] min_bright_reg, min_bright_next;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        fade_mode_next  = fade_mode_reg;
        min_bright_next = min_bright_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                mdfd_pkg::CFG_FADE_MODE:  fade_mode_next  = pwdata[0];
                mdfd_pkg::CFG_MIN_BRIGHT: min_bright_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_mode_reg  <= 1'b0;
            min_bright_reg <= mdfd_pkg::MIN_BRIGHT_RESET;
        end
        else
        begin
            fade_mode_reg  <= fade_mode_next;
            min_bright_reg <= min_bright_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mdfd_pkg::CFG_FADE_MODE:  prdata = 32'(fade_mode_reg);
            mdfd_pkg::CFG_MIN_BRIGHT: prdata = 32'(min_bright_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Accept stage: pick the digit, issue the record read, step the scan
    logic [2:0]       in_req;
    logic [2:0]       in_idx;
    logic [7:0]       in_val;
    logic             in_accept;
    logic             in_is_tick;
    logic             in_is_pair;
    logic [2:0]       in_digit;
    logic             in_ok;
    logic [2:0]       in_addr_full;
    logic [ADDR_W-1:0] rd_addr;

    logic [POS_W-1:0] scan_pos_reg, scan_pos_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_advance;
    logic [2:0]       s1_req_reg;
    logic [2:0]       s1_digit_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic             s1_ok_reg;
    logic [7:0]       s1_val_reg;

    logic             out_valid_reg, out_valid_next;

    assign in_req = s_axis_tuser;
    assign in_idx = s_axis_tdata[2:0];
    assign in_val = s_axis_tdata[10:3];

    assign s1_advance    = s1_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~s1_valid_reg | s1_advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign in_is_tick = (in_req == mdfd_pkg::REQ_SLOT) || (in_req == mdfd_pkg::REQ_COMPARE);
    assign in_is_pair = (in_req == mdfd_pkg::REQ_PAIR);
    assign in_digit   = in_is_tick ? 3'(scan_pos_reg) : in_idx;
    assign in_ok      = in_is_pair ? ({1'b0, in_idx} < NUM_PAIRS_L)
                                   : ({1'b0, in_idx} < NUM_DIGITS_L);
    assign in_addr_full = in_is_pair ? in_idx : {1'b0, in_digit[2:1]};
    assign rd_addr      = in_addr_full[ADDR_W-1:0];

    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        if (in_accept && (in_req == mdfd_pkg::REQ_COMPARE))
        begin
            scan_pos_next = (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;
        end
    end

    assign s1_valid_next = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            scan_pos_reg <= scan_pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg   <= in_req;
            s1_digit_reg <= in_digit;
            s1_addr_reg  <= rd_addr;
            s1_ok_reg    <= in_ok;
            s1_val_reg   <= in_val;
        end
    end

    // ------------------------------------------------------------------
    // Record memories, bank 0 even positions, bank 1 odd positions
    logic [REC_W-1:0]     ram_rdata [2];
    mdfd_pkg::digit_rec_t cur_rec   [2];
    mdfd_pkg::digit_rec_t wr_rec    [2];
    logic                 wr_en     [2];

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic [BANK_DEPTH-1:0] ent_valid_reg;
        logic                  fwd_valid_reg;
        logic [ADDR_W-1:0]     fwd_addr_reg;
        mdfd_pkg::digit_rec_t  fwd_rec_reg;

        mdfd_ram #(
            .WIDTH (REC_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en[b]),
            .waddr (s1_addr_reg),
            .wdata (wr_rec[b]),
            .re    (in_accept),
            .raddr (rd_addr),
            .rdata (ram_rdata[b])
        );

        // Entry written at all since reset, and the last write for bypass
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ent_valid_reg <= '0;
                fwd_valid_reg <= 1'b0;
            end
            else if (wr_en[b])
            begin
                ent_valid_reg[s1_addr_reg] <= 1'b1;
                fwd_valid_reg              <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                fwd_addr_reg <= s1_addr_reg;
                fwd_rec_reg  <= wr_rec[b];
            end
        end

        // Latest write wins, untouched entries read as reset state
        assign cur_rec[b] = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_rec_reg :
                            ent_valid_reg[s1_addr_reg] ?
                                mdfd_pkg::digit_rec_t'(ram_rdata[b]) : mdfd_pkg::REC_RESET;
    end

    // ------------------------------------------------------------------
    // Modify stage
    mdfd_pkg::digit_rec_t sel_rec;
    mdfd_pkg::digit_rec_t step_rec;
    mdfd_pkg::digit_rec_t upd_rec;
    logic [7:0]  div_inc;
    logic [4:0]  lvl_inc;
    logic [15:0] fade_prod;
    logic [16:0] fade_sum;
    logic [7:0]  fade_cmp;
    logic [15:0] tens_prod;
    logic [3:0]  pair_tens;
    logic [7:0]  pair_rem;
    logic [3:0]  pair_units;
    logic [7:0]  bright_clamped;
    logic        single_wr;
    logic        s1_bank;

    logic [1:0] out_kind_reg, out_kind_next;
    logic [5:0] out_sel_reg,  out_sel_next;
    logic [7:0] out_code_reg, out_code_next;
    logic [7:0] out_cmp_reg,  out_cmp_next;

    assign s1_bank = s1_digit_reg[0];
    assign sel_rec = s1_bank ? cur_rec[1] : cur_rec[0];

    // One fade step: divide down, then move the level and reload the compare
    assign div_inc   = sel_rec.divider + 8'd1;
    assign lvl_inc   = (sel_rec.level >= mdfd_pkg::FADE_LAST) ? 5'd0 : sel_rec.level + 5'd1;
    assign fade_prod = mdfd_pkg::level_value(lvl_inc) * sel_rec.bright;
    // floor(x / 255) for x below 65280, which covers every product here
    assign fade_sum  = 17'(fade_prod) + 17'(fade_prod[15:8]) + 17'd1;
    assign fade_cmp  = fade_sum[15:8] + (8'd255 - sel_rec.bright);

    always_comb
    begin
        step_rec = sel_rec;
        if (div_inc == mdfd_pkg::FADE_DIVIDE)
        begin
            step_rec.divider = 8'd0;
            step_rec.level   = lvl_inc;
            step_rec.compare = fade_cmp;
            if (lvl_inc > mdfd_pkg::FADE_SWAP)
            begin
                step_rec.shown = sel_rec.pending;
            end
        end
        else
        begin
            step_rec.divider = div_inc;
        end
    end

    // Pair split: tens by reciprocal multiply, valid below 160
    assign tens_prod  = s1_val_reg * 8'd205;
    assign pair_tens  = tens_prod[14:11];
    assign pair_rem   = s1_val_reg - {1'b0, pair_tens, 3'b000} - {3'b000, pair_tens, 1'b0};
    assign pair_units = pair_rem[3:0];

    assign bright_clamped = (s1_val_reg < min_bright_reg) ? min_bright_reg : s1_val_reg;

    always_comb
    begin
        upd_rec       = sel_rec;
        single_wr     = 1'b0;
        wr_rec[0]     = cur_rec[0];
        wr_rec[1]     = cur_rec[1];
        out_kind_next = mdfd_pkg::KIND_NONE;
        out_sel_next  = '0;
        out_code_next = '0;
        out_cmp_next  = '0;

        unique case (s1_req_reg)
            mdfd_pkg::REQ_SLOT:
            begin
                out_kind_next = mdfd_pkg::KIND_BLANK;
                out_cmp_next  = sel_rec.compare;
                single_wr     = 1'b1;
                if (!fade_mode_reg)
                begin
                    if (sel_rec.blink || (sel_rec.level != 5'd0))
                    begin
                        upd_rec = step_rec;
                    end
                    else
                    begin
                        upd_rec.shown = sel_rec.pending;
                    end
                end
                else if ((sel_rec.shown != sel_rec.pending) || (sel_rec.level != 5'd0))
                begin
                    upd_rec = step_rec;
                end
            end
            mdfd_pkg::REQ_COMPARE:
            begin
                out_kind_next = mdfd_pkg::KIND_DRIVE;
                out_sel_next  = 6'd1 << s1_digit_reg;
                out_code_next = mdfd_pkg::code_pattern(
                    (sel_rec.shown > mdfd_pkg::BLANK_INDEX) ? mdfd_pkg::BLANK_INDEX
                                                            : sel_rec.shown);
            end
            mdfd_pkg::REQ_DIGIT:
            begin
                single_wr       = s1_ok_reg;
                upd_rec.pending = (s1_val_reg >= mdfd_pkg::OFF_CODE) ? mdfd_pkg::BLANK_INDEX
                                                                     : s1_val_reg[3:0];
            end
            mdfd_pkg::REQ_PAIR:
            begin
                if (s1_val_reg >= mdfd_pkg::PAIR_BLANK_MIN)
                begin
                    wr_rec[0].pending = mdfd_pkg::BLANK_INDEX;
                    wr_rec[1].pending = mdfd_pkg::BLANK_INDEX;
                end
                else
                begin
                    wr_rec[0].pending = pair_tens;
                    wr_rec[1].pending = pair_units;
                end
            end
            mdfd_pkg::REQ_BLINK:
            begin
                single_wr     = s1_ok_reg;
                upd_rec.blink = s1_val_reg[0];
            end
            mdfd_pkg::REQ_BRIGHT:
            begin
                single_wr       = s1_ok_reg;
                upd_rec.bright  = bright_clamped;
                upd_rec.compare = 8'd255 - bright_clamped;
            end
            default: ;
        endcase

        // Single-digit updates go to the bank of that digit
        if (s1_req_reg != mdfd_pkg::REQ_PAIR)
        begin
            wr_rec[0] = upd_rec;
            wr_rec[1] = upd_rec;
        end
    end

    // Write back only when the transaction moves on
    always_comb
    begin
        if (s1_req_reg == mdfd_pkg::REQ_PAIR)
        begin
            wr_en[0] = s1_advance & s1_ok_reg;
            wr_en[1] = s1_advance & s1_ok_reg;
        end
        else
        begin
            wr_en[0] = s1_advance & single_wr & ~s1_bank;
            wr_en[1] = s1_advance & single_wr & s1_bank;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    assign out_valid_next = s1_advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_kind_reg <= out_kind_next;
            out_sel_reg  <= out_sel_next;
            out_code_reg <= out_code_next;
            out_cmp_reg  <= out_cmp_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {2'b00, out_cmp_reg, out_code_reg, out_sel_reg};

endmodule

// File: sv/mdfd_checker.sv
`include "multiplexed_digit_fade_driver_defines.svh"

module mdfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Only a digit drive carries a select and a decoder pattern
    `MDFD_ASSERT_NOW(a_drive_fields, m_axis_tvalid && (m_axis_tuser != mdfd_pkg::KIND_DRIVE), m_axis_tdata[13:0] == 14'd0, "select or code outside a digit drive")

    // A drive enables at most one digit
    `MDFD_ASSERT_NOW(a_select_onehot, m_axis_tvalid && (m_axis_tuser == mdfd_pkg::KIND_DRIVE), $onehot0(m_axis_tdata[5:0]), "more than one digit selected")

    // Compare value only with a blank-and-load, and no spare kind
    `MDFD_ASSERT_NOW(a_compare_kind, m_axis_tvalid && ((m_axis_tuser != mdfd_pkg::KIND_BLANK) || (m_axis_tuser == mdfd_pkg::KIND_SPARE)), (m_axis_tdata[21:14] == 8'd0) && (m_axis_tuser != mdfd_pkg::KIND_SPARE), "compare or kind out of place")

    // Input is held off only by a stalled result
    `MDFD_ASSERT_NOW(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

    // A stalled result holds
    `MDFD_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind multiplexed_digit_fade_driver mdfd_checker u_mdfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
